@@ sv/bsie_pkg.sv @@
package bsie_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W = 32;
   localparam int CAP_W = 5;
   localparam int DIDX_W = 4;
   localparam int CNT_OUT_W = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_SWAP   = 3'd4;
   localparam logic [2:0] OP_PEEK   = 3'd5;
   localparam logic [2:0] OP_CLEAR  = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               operation;
      logic [DIDX_W-1:0]        depth_a;
      logic [DIDX_W-1:0]        depth_b;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_OUT_W-1:0]     fill_count;
      logic [1:0]               status;
   } rsp_type;

endpackage

@@ sv/bsie_ram.sv @@
module bsie_ram #(
   parameter int DEPTH = bsie_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [bsie_pkg::DATA_W-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [bsie_pkg::DATA_W-1:0]       rd_data
);

   logic [bsie_pkg::DATA_W-1:0] mem [DEPTH];
   logic [bsie_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bounded_stack_with_indexed_edit.sv @@
// bounded lifo stack with insert, delete and swap at a depth from the top
//
// req channel (valid/ready) carries one operation beat: push, pop, insert,
// delete, swap, peek or clear. every accepted beat yields exactly one rsp
// beat with the value read, the fill count after the operation and a status
// (ok, full refused, empty refused). csr_we/csr_wdata write the capacity;
// the user must do so only while the block is idle, the block does not
// enforce it. the effective limit is min(capacity, DEPTH).
// entries live in one synchronous ram with one write and one read port, so
// push, clear and refused items go straight to the response, pop and peek
// read their entry first, swap reads both entries and writes them back, and
// insert and delete at clamped depth d > 0 run a shift loop. the shift loop
// moves one entry per cycle through the ram ports.
// one item is worked on at a time; req_ready is high only while idle.
//
// reset empties the stack and loads capacity 10; ram contents are not
// cleared. a finished result waits in the rsp register while the receiver
// stalls, and the next item is still accepted meanwhile.
module bounded_stack_with_indexed_edit #(
   parameter int DEPTH = bsie_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bsie_pkg::req_type             req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bsie_pkg::rsp_type             rsp,
   input  logic                          csr_we,
   input  logic [bsie_pkg::CAP_W-1:0]    csr_wdata
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = (FW > bsie_pkg::DIDX_W) ? FW : bsie_pkg::DIDX_W;
   localparam int LW = (FW > bsie_pkg::CAP_W) ? FW : bsie_pkg::CAP_W;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_TAKE    = 7'b0000010,
      S_SHIFT   = 7'b0000100,
      S_SWAP_B  = 7'b0001000,
      S_SWAP_WA = 7'b0010000,
      S_SWAP_WB = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [FW-1:0]                 fill_ff, fill_in;
   logic [bsie_pkg::CAP_W-1:0]    cap_ff;
   logic [2:0]                    op_ff, op_in;
   logic [bsie_pkg::DATA_W-1:0]   val_ff, val_in;
   logic [AW-1:0]                 src_ff, src_in;
   logic [AW-1:0]                 dst_ff, dst_in;
   logic [FW-1:0]                 cnt_ff, cnt_in;
   logic                          pend_ff, pend_in;
   logic                          up_ff, up_in;
   logic [bsie_pkg::DATA_W-1:0]   rd_ff, rd_in;
   logic [1:0]                    status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bsie_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          mem_we;
   logic [AW-1:0]                 mem_wa;
   logic [bsie_pkg::DATA_W-1:0]   mem_wd;
   logic [AW-1:0]                 mem_ra;
   logic [bsie_pkg::DATA_W-1:0]   mem_q;

   logic [CW-1:0]                 fill_w, top_w, da_w, db_w;
   logic [FW-1:0]                 ins_dc, del_dc, swb_dc, rm_dc;
   logic [AW-1:0]                 top_addr, rm_addr, swa_addr, swb_addr;
   logic                          is_full, is_empty, accept;

   bsie_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // depth clamping and bottom-based addresses (depth 0 is at fill-1)
   always_comb begin
      fill_w   = CW'(fill_ff);
      top_w    = fill_w - CW'(1);
      da_w     = CW'(req.depth_a);
      db_w     = CW'(req.depth_b);
      ins_dc   = FW'((da_w > fill_w) ? fill_w : da_w);
      del_dc   = FW'((da_w > top_w) ? top_w : da_w);
      swb_dc   = FW'((db_w > top_w) ? top_w : db_w);
      rm_dc    = (req.operation == bsie_pkg::OP_POP) ? '0 : del_dc;
      top_addr = AW'(fill_ff - FW'(1));
      rm_addr  = AW'(fill_ff - FW'(1) - rm_dc);
      swa_addr = AW'(fill_ff - FW'(1) - del_dc);
      swb_addr = AW'(fill_ff - FW'(1) - swb_dc);
      is_full  = (LW'(fill_ff) >= LW'(cap_ff)) || (fill_ff == FW'(DEPTH));
      is_empty = (fill_ff == '0);
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      up_in        = up_ff;
      rd_in        = rd_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = dst_ff;
      mem_wd       = mem_q;
      mem_ra       = src_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req.operation;
               val_in    = req.value;
               rd_in     = '0;
               status_in = bsie_pkg::ST_OK;
               pend_in   = 1'b0;
               state_in  = S_RESP;
               unique case (req.operation) inside
                  bsie_pkg::OP_PUSH, bsie_pkg::OP_INSERT: begin
                     if (is_full) begin
                        status_in = bsie_pkg::ST_FULL;
                     end else if (req.operation == bsie_pkg::OP_PUSH || ins_dc == '0) begin
                        mem_we  = 1'b1;
                        mem_wa  = AW'(fill_ff);
                        mem_wd  = req.value;
                        fill_in = fill_ff + FW'(1);
                     end else begin
                        src_in   = top_addr;
                        dst_in   = AW'(fill_ff);
                        cnt_in   = ins_dc;
                        up_in    = 1'b0;
                        state_in = S_SHIFT;
                     end
                  end
                  bsie_pkg::OP_POP, bsie_pkg::OP_DELETE: begin
                     if (is_empty) begin
                        status_in = bsie_pkg::ST_EMPTY;
                     end else begin
                        mem_ra   = rm_addr;
                        src_in   = rm_addr + AW'(1);
                        dst_in   = rm_addr;
                        cnt_in   = rm_dc;
                        up_in    = 1'b1;
                        state_in = S_TAKE;
                     end
                  end
                  bsie_pkg::OP_SWAP: begin
                     if (is_empty) begin
                        status_in = bsie_pkg::ST_EMPTY;
                     end else begin
                        mem_ra   = swa_addr;
                        dst_in   = swa_addr;
                        src_in   = swb_addr;
                        state_in = S_SWAP_B;
                     end
                  end
                  bsie_pkg::OP_PEEK: begin
                     if (is_empty) begin
                        status_in = bsie_pkg::ST_EMPTY;
                     end else begin
                        mem_ra   = top_addr;
                        cnt_in   = '0;
                        state_in = S_TAKE;
                     end
                  end
                  bsie_pkg::OP_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TAKE: begin
            rd_in = mem_q;
            if (op_ff == bsie_pkg::OP_PEEK) begin
               state_in = S_RESP;
            end else if (cnt_ff == '0) begin
               fill_in  = fill_ff - FW'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // read one entry per cycle, write it one slot over in the next cycle
            if (cnt_ff != '0) begin
               mem_ra = src_ff;
               src_in = up_ff ? src_ff + AW'(1) : src_ff - AW'(1);
               cnt_in = cnt_ff - FW'(1);
            end
            pend_in = (cnt_ff != '0);
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = dst_ff;
               mem_wd = mem_q;
               dst_in = up_ff ? dst_ff + AW'(1) : dst_ff - AW'(1);
            end else if (cnt_ff == '0) begin
               if (up_ff) begin
                  fill_in = fill_ff - FW'(1);
               end else begin
                  // gap is open at dst, drop the new word in
                  mem_we  = 1'b1;
                  mem_wa  = dst_ff;
                  mem_wd  = val_ff;
                  fill_in = fill_ff + FW'(1);
               end
               state_in = S_RESP;
            end
         end
         S_SWAP_B: begin
            mem_ra   = src_ff;
            val_in   = mem_q;
            state_in = S_SWAP_WA;
         end
         S_SWAP_WA: begin
            mem_we   = 1'b1;
            mem_wa   = dst_ff;
            mem_wd   = mem_q;
            state_in = S_SWAP_WB;
         end
         S_SWAP_WB: begin
            mem_we   = 1'b1;
            mem_wa   = src_ff;
            mem_wd   = val_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_value = rd_ff;
               rsp_in.fill_count = bsie_pkg::CNT_OUT_W'(fill_ff);
               rsp_in.status     = status_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cap_ff       <= bsie_pkg::CAPACITY_RESET;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      up_ff     <= up_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

endmodule

@@ sv/bsie_checker.sv @@
module bsie_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input bsie_pkg::req_type  req,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bsie_pkg::rsp_type  rsp
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req))
      else $error("req beat dropped or changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp beat dropped or changed while stalled");

   // an accepted beat always leaves the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted back to back");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == bsie_pkg::ST_EMPTY |->
         rsp.fill_count == '0 && rsp.read_value == '0)
      else $error("empty refusal with data or nonzero fill");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == bsie_pkg::ST_FULL |-> rsp.read_value == '0)
      else $error("full refusal with data");

endmodule

bind bounded_stack_with_indexed_edit bsie_checker u_checker (.*);

@@ tb/bounded_stack_with_indexed_edit_tb.sv @@
`timescale 1ns / 1ps

module bounded_stack_with_indexed_edit_tb;

   localparam int DEPTH = bsie_pkg::DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS = 94;
   localparam int NUM_PHASES = 11;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   class stack_shadow;
      logic signed [bsie_pkg::DATA_W-1:0] cells [0:DEPTH-1];
      int fill;
      logic [bsie_pkg::CAP_W-1:0] capacity;
      bsie_pkg::rsp_type pending_results [$];
      int errors;
      int op_seen [0:7];
      int full_refusals;
      int empty_refusals;
      int peak_fill;

      function new();
         fill = 0;
         capacity = bsie_pkg::CAPACITY_RESET;
         errors = 0;
         full_refusals = 0;
         empty_refusals = 0;
         peak_fill = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      function int stack_limit();
         return (capacity > DEPTH) ? DEPTH : int'(capacity);
      endfunction

      function int clamp_depth(int d, int hi);
         return (d > hi) ? hi : d;
      endfunction

      function void note_request(bsie_pkg::req_type r);
         bsie_pkg::rsp_type want;
         int d;
         int b;
         logic signed [bsie_pkg::DATA_W-1:0] held;
         want = '0;
         want.status = bsie_pkg::ST_OK;
         op_seen[r.operation]++;
         case (r.operation)
            bsie_pkg::OP_PUSH, bsie_pkg::OP_INSERT: begin
               if (fill >= stack_limit()) begin
                  want.status = bsie_pkg::ST_FULL;
               end else begin
                  d = (r.operation == bsie_pkg::OP_PUSH) ? 0
                                                         : clamp_depth(int'(r.depth_a), fill);
                  for (int i = fill; i > d; i--) cells[i] = cells[i-1];
                  cells[d] = r.value;
                  fill++;
               end
            end
            bsie_pkg::OP_POP, bsie_pkg::OP_DELETE: begin
               if (fill == 0) begin
                  want.status = bsie_pkg::ST_EMPTY;
               end else begin
                  d = (r.operation == bsie_pkg::OP_POP) ? 0
                                                        : clamp_depth(int'(r.depth_a), fill - 1);
                  want.read_value = cells[d];
                  for (int i = d; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            bsie_pkg::OP_SWAP: begin
               if (fill == 0) begin
                  want.status = bsie_pkg::ST_EMPTY;
               end else begin
                  d = clamp_depth(int'(r.depth_a), fill - 1);
                  b = clamp_depth(int'(r.depth_b), fill - 1);
                  held = cells[d];
                  cells[d] = cells[b];
                  cells[b] = held;
               end
            end
            bsie_pkg::OP_PEEK: begin
               if (fill == 0) want.status = bsie_pkg::ST_EMPTY;
               else want.read_value = cells[0];
            end
            bsie_pkg::OP_CLEAR: begin
               fill = 0;
            end
            default: begin
            end
         endcase
         want.fill_count = bsie_pkg::CNT_OUT_W'(fill);
         if (want.status == bsie_pkg::ST_FULL) full_refusals++;
         if (want.status == bsie_pkg::ST_EMPTY) empty_refusals++;
         if (fill > peak_fill) peak_fill = fill;
         pending_results.push_back(want);
      endfunction

      function void check_result(bsie_pkg::rsp_type got);
         bsie_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $error("rsp beat with nothing expected: read_value %0d fill_count %0d status %0d",
                   got.read_value, got.fill_count, got.status);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
            errors++;
         end
         if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bsie_pkg::req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   bsie_pkg::rsp_type rsp;
   logic csr_we = 1'b0;
   logic [bsie_pkg::CAP_W-1:0] csr_wdata = bsie_pkg::CAPACITY_RESET;

   bit idle_on = 1'b1;
   int quiet_cycles = 0;
   stack_shadow shadow = new();

   always #4 clock = ~clock;

   bounded_stack_with_indexed_edit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // beat monitors and watchdog
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) shadow.note_request(req);
      if (!reset && rsp_valid && rsp_ready) shadow.check_result(rsp);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver stalls in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic bsie_pkg::req_type op_beat(input logic [2:0] op, input int da,
                                                 input int db,
                                                 input logic signed [bsie_pkg::DATA_W-1:0] v);
      bsie_pkg::req_type r;
      r.operation = op;
      r.depth_a = bsie_pkg::DIDX_W'(da);
      r.depth_b = bsie_pkg::DIDX_W'(db);
      r.value = v;
      return r;
   endfunction

   function automatic bsie_pkg::req_type random_request(input bit grow);
      bsie_pkg::req_type r;
      int cut [0:6];
      int pick;
      int reach;
      if (grow) begin
         cut = '{40, 50, 65, 73, 85, 93, 96};
      end else begin
         cut = '{12, 40, 48, 68, 80, 90, 95};
      end
      pick = $urandom_range(0, 99);
      if (pick < cut[0]) r.operation = bsie_pkg::OP_PUSH;
      else if (pick < cut[1]) r.operation = bsie_pkg::OP_POP;
      else if (pick < cut[2]) r.operation = bsie_pkg::OP_INSERT;
      else if (pick < cut[3]) r.operation = bsie_pkg::OP_DELETE;
      else if (pick < cut[4]) r.operation = bsie_pkg::OP_SWAP;
      else if (pick < cut[5]) r.operation = bsie_pkg::OP_PEEK;
      else if (pick < cut[6]) r.operation = bsie_pkg::OP_CLEAR;
      else r.operation = OP_UNUSED;
      // half the depths land inside the current fill, the rest anywhere
      reach = (shadow.fill > 15) ? 15 : shadow.fill;
      r.depth_a = $urandom_range(0, 1) ? bsie_pkg::DIDX_W'($urandom_range(0, 15))
                                       : bsie_pkg::DIDX_W'($urandom_range(0, reach));
      r.depth_b = $urandom_range(0, 1) ? bsie_pkg::DIDX_W'($urandom_range(0, 15))
                                       : bsie_pkg::DIDX_W'($urandom_range(0, reach));
      case ($urandom_range(0, 15))
         0: r.value = 32'sh7fffffff;
         1: r.value = 32'sh80000000;
         2: r.value = '0;
         3: r.value = '1;
         default: r.value = $urandom;
      endcase
      return r;
   endfunction

   task automatic send_request(input bsie_pkg::req_type r);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      // let the clock tick first so the last accepted beat is already noted
      @(posedge clock);
      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [bsie_pkg::CAP_W-1:0] cap);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      shadow.capacity = cap;
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [bsie_pkg::CAP_W-1:0] caps [0:NUM_PHASES-1];
      caps = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd7, 5'd16, 5'd12, 5'd10, 5'd5, 5'd16};
      caps[5] = bsie_pkg::CAP_W'($urandom_range(2, 15));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack refusals at reset capacity, then four pushes of edge values
      send_request(op_beat(bsie_pkg::OP_PEEK, 0, 0, 0));
      send_request(op_beat(bsie_pkg::OP_POP, 0, 0, 0));
      send_request(op_beat(bsie_pkg::OP_DELETE, 15, 0, 0));
      send_request(op_beat(bsie_pkg::OP_SWAP, 3, 9, 0));
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, 32'sh7fffffff));
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, 32'sh80000000));
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, -1));
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, 0));
      // insert past the bottom clamps to the fill count
      send_request(op_beat(bsie_pkg::OP_INSERT, 15, 0, 32'sh5a5a5a5a));
      send_request(op_beat(bsie_pkg::OP_INSERT, 1, 0, 32'sha5a5a5a5));
      send_request(op_beat(bsie_pkg::OP_SWAP, 0, 15, 0));
      send_request(op_beat(bsie_pkg::OP_SWAP, 2, 2, 0));
      send_request(op_beat(bsie_pkg::OP_DELETE, 15, 0, 0));
      send_request(op_beat(bsie_pkg::OP_DELETE, 1, 0, 0));
      send_request(op_beat(bsie_pkg::OP_PEEK, 0, 0, 0));
      send_request(op_beat(OP_UNUSED, 15, 15, -1));
      send_request(op_beat(bsie_pkg::OP_POP, 0, 0, 0));
      send_request(op_beat(bsie_pkg::OP_CLEAR, 0, 0, 0));
      send_request(op_beat(bsie_pkg::OP_PEEK, 0, 0, 0));

      // full refusals with a single slot, then capacity dropped below fill
      write_capacity(5'd1);
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, 32'sh00000001));
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, 32'sh00000002));
      send_request(op_beat(bsie_pkg::OP_INSERT, 0, 0, 32'sh00000003));
      write_capacity(5'd0);
      send_request(op_beat(bsie_pkg::OP_PUSH, 0, 0, 32'sh00000004));
      send_request(op_beat(bsie_pkg::OP_POP, 0, 0, 0));

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(caps[p]);
         idle_on = (p != 3) && (p < NUM_PHASES - 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_request(random_request(k < PHASE_ITEMS / 2));
         end
      end

      drain_results();
      repeat (24) @(posedge clock);

      $display("covered push %0d, pop %0d, insert %0d, delete %0d, swap %0d, peek %0d,",
               shadow.op_seen[bsie_pkg::OP_PUSH], shadow.op_seen[bsie_pkg::OP_POP],
               shadow.op_seen[bsie_pkg::OP_INSERT], shadow.op_seen[bsie_pkg::OP_DELETE],
               shadow.op_seen[bsie_pkg::OP_SWAP], shadow.op_seen[bsie_pkg::OP_PEEK]);
      $display("clear %0d, unused %0d; %0d full and %0d empty refusals, peak fill %0d, %0d phases",
               shadow.op_seen[bsie_pkg::OP_CLEAR], shadow.op_seen[OP_UNUSED],
               shadow.full_refusals, shadow.empty_refusals, shadow.peak_fill, NUM_PHASES);
      if (shadow.pending_results.size() != 0) begin
         $error("%0d expected results never arrived", shadow.pending_results.size());
      end
      if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
